/* src/csvt_pkg.sv */
// ----------------------------------------------------------------------------
// csvt_pkg
// shared constants and types of the csv record tokenizer
// ----------------------------------------------------------------------------
package csvt_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = 10;

    // highest column index reported, fields beyond it share it
    localparam logic [COL_W-1:0] COL_LIMIT =
        ((MAX_COLUMNS - 1) < 1023) ? COL_W'(MAX_COLUMNS - 1) : COL_W'(1023);

    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       out_byte;
        logic [COL_W-1:0] column;
    } t_result;

endpackage

/* src/csvt_if.sv */
// ----------------------------------------------------------------------------
// csvt channel interfaces
// byte input, token output and delimiter write channels
// ----------------------------------------------------------------------------
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if import csvt_pkg::*;;
    logic             valid;
    logic             ready;
    t_kind            kind;
    logic [7:0]       out_byte;
    logic [COL_W-1:0] column;

    modport source (output valid, output kind, output out_byte, output column, input ready);
    modport sink   (input valid, input kind, input out_byte, input column, output ready);
endinterface

interface csvt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] delimiter;

    modport source (output valid, output delimiter, input ready);
    modport sink   (input valid, input delimiter, output ready);
endinterface

/* src/csv_record_tokenizer.sv */
// an accepted byte is held in the input register of csvt_core and its result is registered in csvt_out_reg
// throughput: one byte per cycle while the output accepts results, set by the state update in csvt_core
// a byte that yields no token still passes through the input register
// reset (synchronous, active low) empties both registers, restores the delimiter
// to a comma and starts a new record at column zero
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// streaming csv tokenizer emitting content bytes and field and record ends
// ----------------------------------------------------------------------------
module csv_record_tokenizer import csvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csvt_in_if.sink     i_in,
    csvt_cfg_if.sink    i_cfg,
    csvt_out_if.source  o_out
);

    logic    res_valid;
    logic    res_ready;
    t_result res;

    csvt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    csvt_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_out       (o_out)
    );

endmodule

/* src/csvt_core.sv */
// ----------------------------------------------------------------------------
// csvt_core
// input register, tokenizer state and the per-byte next-state logic
// ----------------------------------------------------------------------------
module csvt_core import csvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csvt_in_if.sink     i_in,
    csvt_cfg_if.sink    i_cfg,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eoi;

    logic [7:0]       r_delim;
    logic             r_quoted, n_quoted;
    logic             r_qseen,  n_qseen;
    logic             r_cr,     n_cr;
    logic             r_fresh,  n_fresh;
    logic             r_begun,  n_begun;
    logic [COL_W-1:0] r_field,  n_field;

    logic             emit;
    logic             advance;
    logic             plain;
    logic             fresh_now;

    always_comb begin
        n_quoted  = r_quoted;
        n_qseen   = r_qseen;
        n_cr      = r_cr;
        n_fresh   = r_fresh;
        n_begun   = r_begun;
        n_field   = r_field;
        emit      = 1'b0;
        plain     = 1'b0;
        fresh_now = r_fresh;
        o_res.kind     = KIND_BYTE;
        o_res.out_byte = r_in_byte;
        o_res.column   = r_field;

        if (r_in_eoi) begin
            n_cr = 1'b0;
            if (r_begun) begin
                emit = 1'b1;
                o_res.kind = KIND_RECORD;
            end
            n_quoted = 1'b0;
            n_qseen  = 1'b0;
            n_fresh  = 1'b1;
            n_begun  = 1'b0;
            n_field  = '0;
        end else if (!(r_cr && r_in_byte == CH_LF)) begin
            n_cr = 1'b0;
            if (r_quoted) begin
                if (r_qseen) begin
                    n_qseen = 1'b0;
                    if (r_in_byte == CH_QUOTE) begin
                        emit = 1'b1;
                    end else begin
                        // closing quote, the byte falls to the unquoted rules
                        n_quoted  = 1'b0;
                        n_fresh   = 1'b0;
                        fresh_now = 1'b0;
                        plain     = 1'b1;
                    end
                end else if (r_in_byte == CH_QUOTE) begin
                    n_qseen = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end else begin
                plain = 1'b1;
            end

            if (plain) begin
                if (r_in_byte == r_delim) begin
                    emit       = 1'b1;
                    o_res.kind = KIND_FIELD;
                    if (r_field < COL_LIMIT) begin
                        n_field = r_field + 1'b1;
                    end
                    n_fresh = 1'b1;
                    n_begun = 1'b1;
                end else if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
                    n_cr = (r_in_byte == CH_CR);
                    if (r_begun) begin
                        emit       = 1'b1;
                        o_res.kind = KIND_RECORD;
                        n_quoted   = 1'b0;
                        n_qseen    = 1'b0;
                        n_fresh    = 1'b1;
                        n_begun    = 1'b0;
                        n_field    = '0;
                    end
                end else if (r_in_byte == CH_QUOTE && fresh_now) begin
                    n_quoted = 1'b1;
                    n_fresh  = 1'b0;
                    n_begun  = 1'b1;
                end else begin
                    emit    = 1'b1;
                    n_fresh = 1'b0;
                    n_begun = 1'b1;
                end
            end
        end else begin
            // lf of a crlf pair
            n_cr = 1'b0;
        end

        if (o_res.kind != KIND_BYTE) begin
            o_res.out_byte = '0;
        end
    end

    assign o_res_valid = r_in_valid && emit;
    assign advance     = r_in_valid && (i_res_ready || !emit);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_delim    <= DELIM_RESET;
            r_quoted   <= 1'b0;
            r_qseen    <= 1'b0;
            r_cr       <= 1'b0;
            r_fresh    <= 1'b1;
            r_begun    <= 1'b0;
            r_field    <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_delim <= i_cfg.delimiter;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_quoted <= n_quoted;
                r_qseen  <= n_qseen;
                r_cr     <= n_cr;
                r_fresh  <= n_fresh;
                r_begun  <= n_begun;
                r_field  <= n_field;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

endmodule

/* src/csvt_out_reg.sv */
// ----------------------------------------------------------------------------
// csvt_out_reg
// result register in front of the token output channel
// ----------------------------------------------------------------------------
module csvt_out_reg import csvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    output logic        o_res_ready,
    input  t_result     i_res,
    csvt_out_if.source  o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready    = !r_valid || o_out.ready;
    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_res.kind;
    assign o_out.out_byte = r_res.out_byte;
    assign o_out.column   = r_res.column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* src/csvt_checker.sv */
// ----------------------------------------------------------------------------
// csvt_checker
// port-level checks of the token stream, bound to the top level
// ----------------------------------------------------------------------------
module csvt_checker import csvt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_kind,
    input logic [7:0]       i_out_byte,
    input logic [COL_W-1:0] i_column
);

    logic             r_after_rec;
    logic             r_after_field;
    logic [COL_W-1:0] r_prev_col;
    logic             out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_rec   <= 1'b1;
            r_after_field <= 1'b0;
            r_prev_col    <= '0;
        end else if (out_acc) begin
            r_after_rec   <= (i_kind == KIND_RECORD);
            r_after_field <= (i_kind == KIND_FIELD);
            r_prev_col    <= i_column;
        end
    end

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_out_byte) && $stable(i_column))
        else $error("stalled token changed");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_BYTE |-> i_out_byte == 8'd0)
        else $error("marker carries a byte");

    // first token of a record is in column zero
    a_new_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_rec |-> i_column == '0)
        else $error("record did not restart at column zero");

    a_next_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_field |->
            (i_column == r_prev_col + 1'b1) || (i_column == COL_LIMIT))
        else $error("column did not step after field end");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token shown straight after reset");

endmodule

bind csv_record_tokenizer csvt_checker u_csvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_out_byte  (o_out.out_byte),
    .i_column    (o_out.column)
);
